// File: rtl/core/rsti_pkg.sv
// Shared types and constants for the ring stage task issuer.
// Slot kind codes and the controller/datapath command and status words.
// No dependencies.
`timescale 1ns / 1ps

package rsti_pkg;

  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WB     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOCKED = 3'd4;

  localparam int CNT_OUT_W = 3;
  localparam int MASK_W    = 5;
  localparam int STAGE_W   = 3;

  typedef struct packed {
    logic load;   // latch input word
    logic enq;    // append task to its stage queue
    logic move;   // count slots and rotate ring
    logic rd;     // read head task of current stage
    logic issue;  // try to issue at current stage
  } cmd_t;

  typedef struct packed {
    logic last;   // current stage is the last one
  } status_t;

endpackage

// File: rtl/core/rsti_dp.sv
// Datapath: slot ring, per-stage waiting queues (one shared memory),
// stage walk index and result registers. Uses rsti_pkg.
`timescale 1ns / 1ps

module rsti_dp #(
  parameter int STAGES      = 5,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rsti_pkg::cmd_t                      cmd_i,
  output rsti_pkg::status_t                   status_o,
  input  logic                                task_kind_i,
  input  logic [rsti_pkg::STAGE_W-1:0]        target_stage_i,
  output logic [rsti_pkg::CNT_OUT_W-1:0]      busy_count_o,
  output logic [rsti_pkg::CNT_OUT_W-1:0]      completed_count_o,
  output logic [rsti_pkg::MASK_W-1:0]         issued_mask_o,
  output logic                                enqueue_accepted_o
);

  localparam int SW     = $clog2(STAGES);
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LIFE_W = $clog2(STAGES + 1);
  localparam int MEM_D  = STAGES * QUEUE_DEPTH;
  localparam int AW     = (MEM_D > 1) ? $clog2(MEM_D) : 1;

  logic [rsti_pkg::KIND_W-1:0] kind_q [STAGES];
  logic [rsti_pkg::KIND_W-1:0] kind_d [STAGES];
  logic [LIFE_W-1:0]           life_q [STAGES];
  logic [LIFE_W-1:0]           life_d [STAGES];
  logic [PTR_W-1:0]            head_q [STAGES];
  logic [PTR_W-1:0]            head_d [STAGES];
  logic [PTR_W-1:0]            tail_q [STAGES];
  logic [PTR_W-1:0]            tail_d [STAGES];
  logic [CNT_W-1:0]            count_q[STAGES];
  logic [CNT_W-1:0]            count_d[STAGES];

  logic [SW-1:0]                      idx_q, idx_d;
  logic                               tkind_q;
  logic [rsti_pkg::STAGE_W-1:0]       tstage_q;
  logic                               head_kind_q;
  logic                               mem_q [MEM_D];

  logic [rsti_pkg::CNT_OUT_W-1:0]     busy_cnt_q, busy_cnt_d;
  logic [rsti_pkg::CNT_OUT_W-1:0]     done_cnt_q, done_cnt_d;
  logic [rsti_pkg::MASK_W-1:0]        mask_q, mask_d;
  logic                               acc_q, acc_d;

  logic [STAGES-1:0]                  go;
  logic [STAGES-1:0]                  enq_ok;
  logic [PTR_W-1:0]                   wr_ptr, rd_ptr;
  logic [AW-1:0]                      wr_addr, rd_addr;

  // per-stage issue decision and enqueue acceptance
  always_comb begin
    int p;
    for (int j = 0; j < STAGES; j++) begin
      p = (j == 0) ? STAGES - 1 : j - 1;
      go[j] = cmd_i.issue && (idx_q == SW'(j)) &&
              (kind_q[j] == rsti_pkg::KIND_EMPTY) && (count_q[j] != '0) &&
              (!head_kind_q || (life_q[p] <= LIFE_W'(1)));
      enq_ok[j] = cmd_i.enq && (32'(tstage_q) == j) &&
                  (count_q[j] != CNT_W'(QUEUE_DEPTH));
    end
  end

  always_comb begin
    wr_ptr = '0;
    rd_ptr = '0;
    for (int j = 0; j < STAGES; j++) begin
      if (32'(tstage_q) == j) begin
        wr_ptr = tail_q[j];
      end
      if (idx_q == SW'(j)) begin
        rd_ptr = head_q[j];
      end
    end
    wr_addr = AW'(32'(tstage_q) * QUEUE_DEPTH + 32'(wr_ptr));
    rd_addr = AW'(32'(idx_q) * QUEUE_DEPTH + 32'(rd_ptr));
  end

  // ring update: rotation on move, issue and lock on issue
  always_comb begin
    int p;
    for (int j = 0; j < STAGES; j++) begin
      kind_d[j] = kind_q[j];
      life_d[j] = life_q[j];
    end
    if (cmd_i.move) begin
      for (int j = 0; j < STAGES; j++) begin
        p = (j == 0) ? STAGES - 1 : j - 1;
        if (kind_q[j] == rsti_pkg::KIND_POP) begin
          kind_d[j] = rsti_pkg::KIND_WB;
        end else if (life_q[p] > LIFE_W'(1)) begin
          kind_d[j] = kind_q[p];
          life_d[j] = life_q[p] - LIFE_W'(1);
        end else begin
          kind_d[j] = rsti_pkg::KIND_EMPTY;
          life_d[j] = '0;
        end
      end
    end else begin
      for (int j = 0; j < STAGES; j++) begin
        p = (j == 0) ? STAGES - 1 : j - 1;
        if (go[j] && head_kind_q) begin
          if (kind_q[p] == rsti_pkg::KIND_EMPTY) begin
            kind_d[p] = rsti_pkg::KIND_LOCKED;
          end
          life_d[p] = LIFE_W'(1);
        end
      end
      for (int j = 0; j < STAGES; j++) begin
        if (go[j]) begin
          kind_d[j] = head_kind_q ? rsti_pkg::KIND_POP : rsti_pkg::KIND_PUSH;
          life_d[j] = LIFE_W'(STAGES);
        end
      end
    end
  end

  // queue pointers
  always_comb begin
    for (int j = 0; j < STAGES; j++) begin
      head_d[j]  = head_q[j];
      tail_d[j]  = tail_q[j];
      count_d[j] = count_q[j];
      if (go[j]) begin
        head_d[j]  = (head_q[j] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q[j] + PTR_W'(1);
        count_d[j] = count_q[j] - CNT_W'(1);
      end
      if (enq_ok[j]) begin
        tail_d[j]  = (tail_q[j] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q[j] + PTR_W'(1);
        count_d[j] = count_q[j] + CNT_W'(1);
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.move) begin
      idx_d = '0;
    end else if (cmd_i.issue) begin
      idx_d = idx_q + SW'(1);
    end
  end

  // results
  always_comb begin
    busy_cnt_d = busy_cnt_q;
    done_cnt_d = done_cnt_q;
    mask_d     = mask_q;
    acc_d      = acc_q;
    if (cmd_i.enq) begin
      busy_cnt_d = '0;
      done_cnt_d = '0;
      mask_d     = '0;
      acc_d      = |enq_ok;
    end else if (cmd_i.move) begin
      busy_cnt_d = '0;
      done_cnt_d = '0;
      mask_d     = '0;
      acc_d      = 1'b0;
      for (int j = 0; j < STAGES; j++) begin
        if (kind_q[j] == rsti_pkg::KIND_PUSH || kind_q[j] == rsti_pkg::KIND_POP ||
            kind_q[j] == rsti_pkg::KIND_WB) begin
          busy_cnt_d = busy_cnt_d + rsti_pkg::CNT_OUT_W'(1);
        end
        if (life_q[j] == LIFE_W'(1) && (kind_q[j] == rsti_pkg::KIND_PUSH ||
            kind_q[j] == rsti_pkg::KIND_WB)) begin
          done_cnt_d = done_cnt_d + rsti_pkg::CNT_OUT_W'(1);
        end
      end
    end else if (cmd_i.issue) begin
      mask_d = mask_q | rsti_pkg::MASK_W'(go);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < STAGES; j++) begin
        kind_q[j]  <= rsti_pkg::KIND_EMPTY;
        life_q[j]  <= '0;
        head_q[j]  <= '0;
        tail_q[j]  <= '0;
        count_q[j] <= '0;
      end
      idx_q <= '0;
    end else begin
      for (int j = 0; j < STAGES; j++) begin
        kind_q[j]  <= kind_d[j];
        life_q[j]  <= life_d[j];
        head_q[j]  <= head_d[j];
        tail_q[j]  <= tail_d[j];
        count_q[j] <= count_d[j];
      end
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tkind_q  <= task_kind_i;
      tstage_q <= target_stage_i;
    end
    busy_cnt_q <= busy_cnt_d;
    done_cnt_q <= done_cnt_d;
    mask_q     <= mask_d;
    acc_q      <= acc_d;
  end

  // waiting task memory
  always_ff @(posedge clk_i) begin
    if (|enq_ok) begin
      mem_q[wr_addr] <= tkind_q;
    end
    if (cmd_i.rd) begin
      head_kind_q <= mem_q[rd_addr];
    end
  end

  assign status_o.last      = (idx_q == SW'(STAGES - 1));
  assign busy_count_o       = busy_cnt_q;
  assign completed_count_o  = done_cnt_q;
  assign issued_mask_o      = mask_q;
  assign enqueue_accepted_o = acc_q;

endmodule

// File: rtl/core/rsti_ctrl.sv
// Controller: sequences enqueue and tick words through the datapath.
// Uses rsti_pkg command and status types.
`timescale 1ns / 1ps

module rsti_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              mode_i,
  output logic              done_o,
  output rsti_pkg::cmd_t    cmd_o,
  input  rsti_pkg::status_t status_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ENQ   = 3'd1;
  localparam logic [2:0] ST_MOVE  = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_ISS   = 3'd4;
  localparam logic [2:0] ST_REPLY = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = mode_i ? ST_MOVE : ST_ENQ;
        end
      end
      ST_ENQ: begin
        cmd_o.enq = 1'b1;
        state_d   = ST_REPLY;
      end
      ST_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_ISS;
      end
      ST_ISS: begin
        cmd_o.issue = 1'b1;
        state_d     = status_i.last ? ST_REPLY : ST_RD;
      end
      ST_REPLY: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_REPLY);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not make block busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("result strobe not followed by idle");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.enq, cmd_o.move, cmd_o.rd, cmd_o.issue}))
    else $error("datapath commands overlap");

  a_rd_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> cmd_o.issue)
    else $error("head read not followed by issue");

endmodule

// File: rtl/core/ring_stage_task_issuer.sv
// Ring stage task issuer, top level: controller plus datapath.
// Enqueue word: the enqueue state, then done_o in the reply state; next word once idle again.
// Tick word: a move step, then one head read and one issue step per stage from the
// shared waiting memory, then done_o in the reply state; next word once idle again.
// Reset clears the ring and all queue pointers; memory contents stay unknown.
// Results appear for one cycle on done_o; the receiver cannot stall.
`timescale 1ns / 1ps

module ring_stage_task_issuer #(
  parameter int STAGES      = 5,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             mode_i,
  input  logic                             task_kind_i,
  input  logic [rsti_pkg::STAGE_W-1:0]     target_stage_i,
  output logic                             done_o,
  output logic [rsti_pkg::CNT_OUT_W-1:0]   busy_count_o,
  output logic [rsti_pkg::CNT_OUT_W-1:0]   completed_count_o,
  output logic [rsti_pkg::MASK_W-1:0]      issued_mask_o,
  output logic                             enqueue_accepted_o
);

  rsti_pkg::cmd_t    cmd;
  rsti_pkg::status_t status;

  rsti_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .mode_i   (mode_i),
    .done_o   (done_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  rsti_dp #(
    .STAGES      (STAGES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .task_kind_i        (task_kind_i),
    .target_stage_i     (target_stage_i),
    .busy_count_o       (busy_count_o),
    .completed_count_o  (completed_count_o),
    .issued_mask_o      (issued_mask_o),
    .enqueue_accepted_o (enqueue_accepted_o)
  );

endmodule
